// ===== sv/aat_pkg.sv =====
// aat_pkg: shared constants and types for the box affine transform
// no dependencies; used by aat_row and aabb_affine_transform
package aat_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 14;
    localparam int COEF_BITS      = 16;
    localparam int NUM_AXES       = 3;
    localparam int ROW_BITS       = 64;

    // apb register map, 64-bit registers at 8-byte spacing
    localparam int ADDR_BITS    = 5;
    localparam int REG_IDX_LSB  = 3;
    localparam int REG_IDX_BITS = ADDR_BITS - REG_IDX_LSB;

    localparam logic [REG_IDX_BITS-1:0] REG_ROW_X = 2'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_ROW_Y = 2'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_ROW_Z = 2'd2;

    // pipeline stage enables from the top level to the row units
    typedef struct packed {
        logic prod_en;
        logic out_en;
    } aat_ctrl_t;

endpackage

// ===== sv/aat_row.sv =====
// aat_row: one output axis; registered products, then min/max sum, shift, translation and saturation
// depends on aat_pkg
module aat_row #(
    parameter int COORD_BITS = aat_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = aat_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  aat_pkg::aat_ctrl_t            ctrl,
    input  logic [aat_pkg::ROW_BITS-1:0]  row,
    input  logic signed [COORD_BITS-1:0]  lo [aat_pkg::NUM_AXES],
    input  logic signed [COORD_BITS-1:0]  hi [aat_pkg::NUM_AXES],
    output logic signed [COORD_BITS-1:0]  out_lo,
    output logic signed [COORD_BITS-1:0]  out_hi,
    output logic                          clip
);

    localparam int PROD_BITS  = aat_pkg::COEF_BITS + COORD_BITS;
    localparam int SUM_BITS   = PROD_BITS + $clog2(aat_pkg::NUM_AXES);
    localparam int BOUND_BITS = SUM_BITS + 1;
    localparam logic signed [BOUND_BITS-1:0] B_MAX =
        BOUND_BITS'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
    localparam logic signed [BOUND_BITS-1:0] B_MIN = -B_MAX - BOUND_BITS'(1);

    logic signed [aat_pkg::COEF_BITS-1:0] coef [aat_pkg::NUM_AXES];
    logic signed [aat_pkg::COEF_BITS-1:0] trans;
    logic signed [PROD_BITS-1:0] prod_lo_next [aat_pkg::NUM_AXES];
    logic signed [PROD_BITS-1:0] prod_hi_next [aat_pkg::NUM_AXES];
    logic signed [PROD_BITS-1:0] prod_lo_reg  [aat_pkg::NUM_AXES];
    logic signed [PROD_BITS-1:0] prod_hi_reg  [aat_pkg::NUM_AXES];
    logic signed [SUM_BITS-1:0]  sum_lo;
    logic signed [SUM_BITS-1:0]  sum_hi;
    logic signed [BOUND_BITS-1:0] bound_lo;
    logic signed [BOUND_BITS-1:0] bound_hi;
    logic signed [COORD_BITS-1:0] out_lo_next;
    logic signed [COORD_BITS-1:0] out_hi_next;
    logic                         clip_next;
    logic signed [COORD_BITS-1:0] out_lo_reg;
    logic signed [COORD_BITS-1:0] out_hi_reg;
    logic                         clip_reg;

    // one multiplier pair per column
    always_comb
    begin
        for (int j = 0; j < aat_pkg::NUM_AXES; j++)
        begin
            coef[j]         = signed'(row[aat_pkg::COEF_BITS*j +: aat_pkg::COEF_BITS]);
            prod_lo_next[j] = PROD_BITS'(coef[j]) * PROD_BITS'(lo[j]);
            prod_hi_next[j] = PROD_BITS'(coef[j]) * PROD_BITS'(hi[j]);
        end
        trans = signed'(row[aat_pkg::COEF_BITS*aat_pkg::NUM_AXES +: aat_pkg::COEF_BITS]);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.prod_en)
        begin
            prod_lo_reg <= prod_lo_next;
            prod_hi_reg <= prod_hi_next;
        end
    end

    // per column min/max, floor shift, translation, saturation
    always_comb
    begin
        sum_lo = '0;
        sum_hi = '0;
        for (int j = 0; j < aat_pkg::NUM_AXES; j++)
        begin
            if (prod_lo_reg[j] < prod_hi_reg[j])
            begin
                sum_lo = sum_lo + SUM_BITS'(prod_lo_reg[j]);
                sum_hi = sum_hi + SUM_BITS'(prod_hi_reg[j]);
            end
            else
            begin
                sum_lo = sum_lo + SUM_BITS'(prod_hi_reg[j]);
                sum_hi = sum_hi + SUM_BITS'(prod_lo_reg[j]);
            end
        end
        bound_lo  = BOUND_BITS'(sum_lo >>> FRAC_BITS) + BOUND_BITS'(trans);
        bound_hi  = BOUND_BITS'(sum_hi >>> FRAC_BITS) + BOUND_BITS'(trans);
        clip_next = 1'b0;
        priority if (bound_lo > B_MAX)
        begin
            out_lo_next = B_MAX[COORD_BITS-1:0];
            clip_next   = 1'b1;
        end
        else if (bound_lo < B_MIN)
        begin
            out_lo_next = B_MIN[COORD_BITS-1:0];
            clip_next   = 1'b1;
        end
        else
        begin
            out_lo_next = bound_lo[COORD_BITS-1:0];
        end
        priority if (bound_hi > B_MAX)
        begin
            out_hi_next = B_MAX[COORD_BITS-1:0];
            clip_next   = 1'b1;
        end
        else if (bound_hi < B_MIN)
        begin
            out_hi_next = B_MIN[COORD_BITS-1:0];
            clip_next   = 1'b1;
        end
        else
        begin
            out_hi_next = bound_hi[COORD_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.out_en)
        begin
            out_lo_reg <= out_lo_next;
            out_hi_reg <= out_hi_next;
            clip_reg   <= clip_next;
        end
    end

    assign out_lo = out_lo_reg;
    assign out_hi = out_hi_reg;
    assign clip   = clip_reg;

endmodule

// ===== sv/aabb_affine_transform.sv =====
// aabb_affine_transform: top level, apb matrix registers, stream handshake and pipeline valids
// depends on aat_pkg and aat_row
//
// usage
//   s_axis carries one box per transfer; m_axis returns the enclosing box of
//   its eight transformed corners, one result per box, in order.
//   the 3x4 matrix lives in three 64-bit apb registers: row_x at 0x00,
//   row_y at 0x08, row_z at 0x10; write them only while the stream is idle.
//   an input transfer passes through three registers before it shows on
//   m_axis_tvalid: input register, product register (18 multipliers),
//   result register (sum, shift, saturate).
//   throughput is one box per cycle while m_axis_tready is high, set by the
//   single pass through the multipliers and the adder per axis.
//   a stage fills when empty or the next moves, so a stalled receiver first lets
//   bubbles close up; s_axis_tready drops only when all three stages hold data.
//   reset empties the pipeline and loads the identity transform.
module aabb_affine_transform #(
    parameter int COORD_BITS = aat_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = aat_pkg::FRAC_BITS_DEF,
    localparam int DATA_BITS = ((2 * aat_pkg::NUM_AXES * COORD_BITS + 7) / 8) * 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // apb
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [aat_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [aat_pkg::ROW_BITS-1:0]   pwdata,
    output logic [aat_pkg::ROW_BITS-1:0]   prdata,
    output logic                           pready,
    // in: min_x, min_y, min_z, max_x, max_y, max_z
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [DATA_BITS-1:0]           s_axis_tdata,
    // out: out_min_x, out_min_y, out_min_z, out_max_x, out_max_y, out_max_z
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [DATA_BITS-1:0]           m_axis_tdata,
    // out: saturated
    output logic                           m_axis_tuser
);

    localparam int NA = aat_pkg::NUM_AXES;
    localparam logic [aat_pkg::ROW_BITS-1:0] ONE_COEF =
        aat_pkg::ROW_BITS'(aat_pkg::COEF_BITS'(64'd1 << FRAC_BITS));
    localparam logic signed [COORD_BITS-1:0] SAT_MAX =
        COORD_BITS'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
    localparam logic signed [COORD_BITS-1:0] SAT_MIN = -SAT_MAX - COORD_BITS'(1);

    logic [aat_pkg::ROW_BITS-1:0]     row_reg  [NA];
    logic [aat_pkg::ROW_BITS-1:0]     row_next [NA];
    logic [aat_pkg::REG_IDX_BITS-1:0] reg_idx;
    logic                             cfg_we;

    logic signed [COORD_BITS-1:0] in_lo_reg [NA];
    logic signed [COORD_BITS-1:0] in_hi_reg [NA];
    logic signed [COORD_BITS-1:0] res_lo    [NA];
    logic signed [COORD_BITS-1:0] res_hi    [NA];
    logic [NA-1:0]                res_clip;

    logic in_valid_reg;
    logic prod_valid_reg;
    logic out_valid_reg;
    logic out_free;
    logic prod_free;
    logic in_free;
    aat_pkg::aat_ctrl_t ctrl;

    // configuration
    assign pready  = 1'b1;
    assign reg_idx = paddr[aat_pkg::ADDR_BITS-1:aat_pkg::REG_IDX_LSB];
    assign cfg_we  = psel && penable && pwrite && pready;

    always_comb
    begin
        row_next = row_reg;
        if (cfg_we)
        begin
            unique case (reg_idx)
                aat_pkg::REG_ROW_X: row_next[0] = pwdata;
                aat_pkg::REG_ROW_Y: row_next[1] = pwdata;
                aat_pkg::REG_ROW_Z: row_next[2] = pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            aat_pkg::REG_ROW_X: prdata = row_reg[0];
            aat_pkg::REG_ROW_Y: prdata = row_reg[1];
            aat_pkg::REG_ROW_Z: prdata = row_reg[2];
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < NA; r++)
            begin
                row_reg[r] <= ONE_COEF << (aat_pkg::COEF_BITS * r);
            end
        end
        else
        begin
            row_reg <= row_next;
        end
    end

    // pipeline control, each stage moves when it is empty or the next one moves
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign prod_free     = !prod_valid_reg || out_free;
    assign in_free       = !in_valid_reg || prod_free;
    assign s_axis_tready = in_free;
    assign ctrl.prod_en  = in_valid_reg && prod_free;
    assign ctrl.out_en   = prod_valid_reg && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_free)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (prod_free)
            begin
                prod_valid_reg <= in_valid_reg;
            end
            if (out_free)
            begin
                out_valid_reg <= prod_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && in_free)
        begin
            for (int j = 0; j < NA; j++)
            begin
                in_lo_reg[j] <= signed'(s_axis_tdata[COORD_BITS*j +: COORD_BITS]);
                in_hi_reg[j] <= signed'(s_axis_tdata[COORD_BITS*(j+NA) +: COORD_BITS]);
            end
        end
    end

    for (genvar r = 0; r < NA; r++)
    begin : g_row
        aat_row #(
            .COORD_BITS (COORD_BITS),
            .FRAC_BITS  (FRAC_BITS)
        ) u_row (
            .clk    (clk),
            .ctrl   (ctrl),
            .row    (row_reg[r]),
            .lo     (in_lo_reg),
            .hi     (in_hi_reg),
            .out_lo (res_lo[r]),
            .out_hi (res_hi[r]),
            .clip   (res_clip[r])
        );
    end

    always_comb
    begin
        m_axis_tdata = '0;
        for (int r = 0; r < NA; r++)
        begin
            m_axis_tdata[COORD_BITS*r +: COORD_BITS]      = res_lo[r];
            m_axis_tdata[COORD_BITS*(r+NA) +: COORD_BITS] = res_hi[r];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = |res_clip;

    // a new result is only loaded from an item held in the product stage
    a_out_from_prod: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(prod_valid_reg))
        else $error("result valid without a product stage item");

    // input backpressure only when the whole pipeline is full and stalled
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !s_axis_tready) |->
        (prod_valid_reg && out_valid_reg && !m_axis_tready))
        else $error("input stalled with room in the pipeline");

    // a saturation flag needs at least one bound at a limit
    a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |->
        (res_lo[0] == SAT_MAX || res_lo[0] == SAT_MIN ||
         res_lo[1] == SAT_MAX || res_lo[1] == SAT_MIN ||
         res_lo[2] == SAT_MAX || res_lo[2] == SAT_MIN ||
         res_hi[0] == SAT_MAX || res_hi[0] == SAT_MIN ||
         res_hi[1] == SAT_MAX || res_hi[1] == SAT_MIN ||
         res_hi[2] == SAT_MAX || res_hi[2] == SAT_MIN))
        else $error("saturated flag set with no bound at a limit");

endmodule
